FILE: sv/svpp_pkg.sv
// ----------------------------------------------------------------------------
// svpp_pkg
// Shared types and constants of the state variable packet parser.
// ----------------------------------------------------------------------------
package svpp_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned KEY_W         = 48;
  localparam int unsigned HDR_LEN       = 21;

  localparam logic [15:0] MSG_DISCOVER = 16'h0000;
  localparam logic [15:0] MSG_SET      = 16'h0100;
  localparam logic [15:0] MSG_GET      = 16'h0103;
  localparam logic [15:0] NODE_NONE    = 16'hFFFF;
  localparam logic [15:0] VALUE_NONE   = 16'hFFFF;

  typedef enum logic [2:0] {
    OP_BYTE     = 3'd0,
    OP_REGISTER = 3'd1,
    OP_READ     = 3'd2,
    OP_WRITE    = 3'd3,
    OP_RESTART  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_LENGTH = 2'd1,
    ERR_TYPE   = 2'd2,
    ERR_COUNT  = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    TOP_REGISTER = 2'd0,
    TOP_READ     = 2'd1,
    TOP_WRITE    = 2'd2
  } tbl_op_e;

  typedef struct packed {
    logic             valid;
    tbl_op_e          op;
    logic [KEY_W-1:0] key;
    logic [15:0]      wval;
  } tbl_req_t;

  typedef struct packed {
    logic        done;
    logic        found;
    logic        full;
    logic [15:0] rdata;
  } tbl_rsp_t;

  typedef struct packed {
    logic             uvalid;
    logic [15:0]      uvid;
    logic [15:0]      uval;
    logic             done;
    logic             capt;
    err_e             err;
    logic [15:0]      node;
    logic [KEY_W-1:0] key;
  } pstep_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic        update_valid;
    logic [15:0] update_var_id;
    logic [15:0] update_value;
    logic        update_matched;
    logic        frame_done;
    logic [15:0] peer_node;
    logic        node_known;
    logic        node_captured;
    logic [1:0]  error_code;
    logic        table_full;
  } res_t;

endpackage

FILE: sv/svpp_in_if.sv
// ----------------------------------------------------------------------------
// svpp_in_if
// Input word channel: opcode, received byte and table access fields.
// ----------------------------------------------------------------------------
interface svpp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [7:0]  rx_byte;
  logic [31:0] object_id;
  logic [15:0] var_id;
  logic [15:0] new_value;

  modport source (output valid, opcode, rx_byte, object_id, var_id, new_value, input ready);
  modport sink (input valid, opcode, rx_byte, object_id, var_id, new_value, output ready);
endinterface

FILE: sv/svpp_out_if.sv
// ----------------------------------------------------------------------------
// svpp_out_if
// Result word channel of the packet parser.
// ----------------------------------------------------------------------------
interface svpp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_value;
  logic        update_valid;
  logic [15:0] update_var_id;
  logic [15:0] update_value;
  logic        update_matched;
  logic        frame_done;
  logic [15:0] peer_node;
  logic        node_known;
  logic        node_captured;
  logic [1:0]  error_code;
  logic        table_full;

  modport source (output valid, read_value, update_valid, update_var_id, update_value,
                  update_matched, frame_done, peer_node, node_known, node_captured,
                  error_code, table_full, input ready);
  modport sink (input valid, read_value, update_valid, update_var_id, update_value,
                update_matched, frame_done, peer_node, node_known, node_captured,
                error_code, table_full, output ready);
endinterface

FILE: sv/svpp_table.sv
// ----------------------------------------------------------------------------
// svpp_table
// Variable table in two synchronous memories; linear first-match scan,
// one entry per cycle, with write-back of the new value on a write hit.
// ----------------------------------------------------------------------------
module svpp_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  svpp_pkg::tbl_req_t  req_i,
  output svpp_pkg::tbl_rsp_t  rsp_o
);
  import svpp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_REG  = 2'd2;

  logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];
  logic [15:0]      val_mem [TABLE_ENTRIES];

  logic [1:0]       st_q, st_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] nxt_q, nxt_d;
  logic [IDX_W-1:0] chk_q, chk_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [15:0]      wval_q, wval_d;
  logic             wr_q, wr_d;
  tbl_rsp_t         rsp_q, rsp_d;

  logic [IDX_W-1:0] rd_addr;
  logic [KEY_W-1:0] key_rd;
  logic [15:0]      val_rd;
  logic             kwe, vwe;
  logic [IDX_W-1:0] vaddr;
  logic [15:0]      vdata;
  logic             last;

  always_ff @(posedge clk_i) begin
    key_rd <= key_mem[rd_addr];
    val_rd <= val_mem[rd_addr];
    if (kwe) begin
      key_mem[cnt_q[IDX_W-1:0]] <= key_q;
    end
    if (vwe) begin
      val_mem[vaddr] <= vdata;
    end
  end

  assign last = ({1'b0, chk_q} == cnt_q - CNT_W'(1));

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    nxt_d   = nxt_q;
    chk_d   = chk_q;
    key_d   = key_q;
    wval_d  = wval_q;
    wr_d    = wr_q;
    rsp_d   = '0;
    rd_addr = nxt_q;
    kwe     = 1'b0;
    vwe     = 1'b0;
    vaddr   = chk_q;
    vdata   = wval_q;
    case (st_q)
      ST_IDLE: begin
        rd_addr = '0;
        if (req_i.valid) begin
          key_d  = req_i.key;
          wval_d = req_i.wval;
          wr_d   = (req_i.op == TOP_WRITE);
          if (req_i.op == TOP_REGISTER) begin
            if (cnt_q < CNT_W'(TABLE_ENTRIES)) begin
              st_d = ST_REG;
            end else begin
              rsp_d.done = 1'b1;
              rsp_d.full = 1'b1;
            end
          end else if (cnt_q == '0) begin
            rsp_d.done = 1'b1;
          end else begin
            st_d  = ST_SCAN;
            chk_d = '0;
            nxt_d = IDX_W'(1);
          end
        end
      end
      ST_REG: begin
        kwe        = 1'b1;
        vwe        = 1'b1;
        vaddr      = cnt_q[IDX_W-1:0];
        vdata      = '0;
        cnt_d      = cnt_q + CNT_W'(1);
        rsp_d.done = 1'b1;
        st_d       = ST_IDLE;
      end
      ST_SCAN: begin
        if (key_rd == key_q) begin
          rsp_d.done  = 1'b1;
          rsp_d.found = 1'b1;
          rsp_d.rdata = val_rd;
          st_d        = ST_IDLE;
          vwe         = wr_q;
        end else if (last) begin
          rsp_d.done = 1'b1;
          st_d       = ST_IDLE;
        end else begin
          chk_d = nxt_q;
          nxt_d = nxt_q + IDX_W'(1);
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      cnt_q <= '0;
      rsp_q <= '0;
      nxt_q <= '0;
      chk_q <= '0;
      wr_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      rsp_q <= rsp_d;
      nxt_q <= nxt_d;
      chk_q <= chk_d;
      wr_q  <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    wval_q <= wval_d;
  end

  assign rsp_o = rsp_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.found |-> rsp_o.done)
    else $error("hit reported without completion");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SCAN) |-> ({1'b0, chk_q} < cnt_q))
    else $error("scan beyond registered entries");

  a_no_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !req_i.valid)
    else $error("request while table busy");

endmodule

FILE: sv/svpp_parser.sv
// ----------------------------------------------------------------------------
// svpp_parser
// Frame parser: header capture, payload record decode, peer node register.
// ----------------------------------------------------------------------------
module svpp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              restart_i,
  input  logic [7:0]        byte_i,
  output svpp_pkg::pstep_t  step_o
);
  import svpp_pkg::*;

  localparam logic [3:0] PH_HEADER = 4'd0;
  localparam logic [3:0] PH_SKIP   = 4'd1;
  localparam logic [3:0] PH_LEAD   = 4'd2;
  localparam logic [3:0] PH_COUNT  = 4'd3;
  localparam logic [3:0] PH_VIDH   = 4'd4;
  localparam logic [3:0] PH_VIDL   = 4'd5;
  localparam logic [3:0] PH_TYPE   = 4'd6;
  localparam logic [3:0] PH_V1     = 4'd7;
  localparam logic [3:0] PH_VH     = 4'd8;
  localparam logic [3:0] PH_VL     = 4'd9;

  localparam logic [4:0]  LAST_POS = 5'(HDR_LEN - 1);
  localparam logic [15:0] HDR_LEN16 = 16'(HDR_LEN);

  logic [4:0]  pos_q, pos_d;
  logic [15:0] pay_q, pay_d;
  logic [3:0]  ph_q, ph_d;
  logic [7:0]  recs_q, recs_d;
  logic [15:0] vid_q, vid_d;
  logic [7:0]  vh_q, vh_d;
  logic [15:0] node_q, node_d;
  logic [7:0]  h1_q, h2_q, h3_q, h4_q, h5_q, h6_q, h7_q, h8_q, h9_q, h10_q, h17_q, h18_q;
  logic [7:0]  h1_d, h2_d, h3_d, h4_d, h5_d, h6_d, h7_d, h8_d, h9_d, h10_d, h17_d, h18_d;

  pstep_t      s;
  logic [4:0]  pos;
  logic [15:0] len, msg, pl;
  logic [7:0]  rn;
  logic        fin;
  logic [3:0]  phn;

  always_comb begin
    pos_d = pos_q; pay_d = pay_q; ph_d = ph_q; recs_d = recs_q;
    vid_d = vid_q; vh_d = vh_q; node_d = node_q;
    h1_d = h1_q; h2_d = h2_q; h3_d = h3_q; h4_d = h4_q; h5_d = h5_q; h6_d = h6_q;
    h7_d = h7_q; h8_d = h8_q; h9_d = h9_q; h10_d = h10_q; h17_d = h17_q; h18_d = h18_q;
    s   = '0;
    s.err = ERR_NONE;
    pos = (pos_q > LAST_POS) ? '0 : pos_q;
    len = {h3_q, h4_q};
    msg = {h17_q, h18_q};
    pl  = '0;
    rn  = '0;
    fin = 1'b0;
    phn = ph_q;
    if (restart_i) begin
      node_d = NODE_NONE;
      pos_d  = '0;
      pay_d  = '0;
      ph_d   = PH_HEADER;
      recs_d = '0;
      vid_d  = '0;
      vh_d   = '0;
    end else if (en_i) begin
      if (ph_q == PH_HEADER) begin
        case (pos)
          5'd1:    h1_d  = byte_i;
          5'd2:    h2_d  = byte_i;
          5'd3:    h3_d  = byte_i;
          5'd4:    h4_d  = byte_i;
          5'd5:    h5_d  = byte_i;
          5'd6:    h6_d  = byte_i;
          5'd7:    h7_d  = byte_i;
          5'd8:    h8_d  = byte_i;
          5'd9:    h9_d  = byte_i;
          5'd10:   h10_d = byte_i;
          5'd17:   h17_d = byte_i;
          5'd18:   h18_d = byte_i;
          default: ;
        endcase
        pos_d = pos + 5'd1;
        if (pos == LAST_POS) begin
          pos_d = '0;
          pl    = (len >= HDR_LEN16) ? len - HDR_LEN16 : '0;
          pay_d = pl;
          ph_d  = PH_SKIP;
          if (h1_q != '0 || h2_q != '0) begin
            s.err = ERR_LENGTH;
          end else if (msg == MSG_DISCOVER) begin
            if (node_q == NODE_NONE) begin
              node_d = {h5_q, h6_q};
              s.capt = 1'b1;
            end
          end else if (msg == MSG_SET || msg == MSG_GET) begin
            if (pl == '0) begin
              s.err = ERR_COUNT;
            end else begin
              ph_d = PH_LEAD;
            end
          end
          if (pl == '0) begin
            s.done = 1'b1;
            ph_d   = PH_HEADER;
          end
        end
      end else begin
        pl    = (pay_q != '0) ? pay_q - 16'd1 : pay_q;
        pay_d = pl;
        case (ph_q)
          PH_LEAD:  phn = PH_COUNT;
          PH_COUNT: begin
            recs_d = byte_i;
            if (byte_i == '0) begin
              fin = 1'b1;
            end else begin
              phn = PH_VIDH;
            end
          end
          PH_VIDH: begin
            vid_d = {byte_i, 8'h00};
            phn   = PH_VIDL;
          end
          PH_VIDL: begin
            vid_d = {vid_q[15:8], byte_i};
            phn   = PH_TYPE;
          end
          PH_TYPE: begin
            if (byte_i == 8'd1) begin
              phn = PH_V1;
            end else if (byte_i == 8'd3) begin
              phn = PH_VH;
            end else begin
              s.err = ERR_TYPE;
              phn   = PH_SKIP;
            end
          end
          PH_VH: begin
            vh_d = byte_i;
            phn  = PH_VL;
          end
          PH_V1, PH_VL: begin
            s.uvalid = 1'b1;
            s.uvid   = vid_q;
            s.uval   = (ph_q == PH_V1) ? {8'h00, byte_i} : {vh_q, byte_i};
            rn       = (recs_q != '0) ? recs_q - 8'd1 : recs_q;
            recs_d   = rn;
            if (rn == '0) begin
              fin = 1'b1;
            end else begin
              phn = PH_VIDH;
            end
          end
          default: phn = PH_SKIP;
        endcase
        if (fin) begin
          phn = PH_SKIP;
          if (pl != '0) begin
            s.err = ERR_COUNT;
          end
        end
        if (pl == '0) begin
          if (phn != PH_SKIP && s.err == ERR_NONE) begin
            s.err = ERR_COUNT;
          end
          s.done = 1'b1;
          phn    = PH_HEADER;
          pos_d  = '0;
        end
        ph_d = phn;
      end
    end
    s.node = node_d;
    s.key  = {h10_q, h9_q, h8_q, h7_q, s.uvid};
  end

  assign step_o = s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      pay_q  <= '0;
      ph_q   <= PH_HEADER;
      recs_q <= '0;
      vid_q  <= '0;
      vh_q   <= '0;
      node_q <= NODE_NONE;
    end else begin
      pos_q  <= pos_d;
      pay_q  <= pay_d;
      ph_q   <= ph_d;
      recs_q <= recs_d;
      vid_q  <= vid_d;
      vh_q   <= vh_d;
      node_q <= node_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h1_q <= h1_d; h2_q <= h2_d; h3_q <= h3_d; h4_q <= h4_d; h5_q <= h5_d; h6_q <= h6_d;
    h7_q <= h7_d; h8_q <= h8_d; h9_q <= h9_d; h10_q <= h10_d;
    h17_q <= h17_d; h18_q <= h18_d;
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LAST_POS)
    else $error("header position out of range");

  a_pos_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ph_q != PH_HEADER) |-> (pos_q == '0))
    else $error("header position held during payload");

  a_done_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && !restart_i && step_o.done) |=> (ph_q == PH_HEADER))
    else $error("frame end without return to header");

endmodule

FILE: sv/state_variable_packet_parser.sv
// ----------------------------------------------------------------------------
// state_variable_packet_parser
// Control-message byte parser with a table of registered state variables.
// ----------------------------------------------------------------------------
// One word is handled at a time. A received byte that completes no record,
// a restart or an unused opcode goes from the accept straight to the finish
// state. A register request writes a new entry, or is refused when the table
// is full, without a scan. A read, a local write or a completed record scans
// the variable table memory one entry per cycle until the first hit or the
// last registered entry; an empty table answers without a scan. The finish
// state holds while the output register still holds an unaccepted result.
// The table keeps its contents across a restart; the result register lets
// the next word be accepted while a result still waits.
module state_variable_packet_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  svpp_in_if.sink    in_i,
  svpp_out_if.source out_o
);
  import svpp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] st_q, st_d;
  logic       ov_q, ov_d;
  res_t       res_q, res_d, out_q;
  logic [2:0] op_q;
  logic       acc;
  pstep_t     ps;
  tbl_req_t   req;
  tbl_rsp_t   rsp;
  logic       free;

  assign in_i.ready = (st_q == ST_IDLE);
  assign acc        = in_i.valid && in_i.ready;
  assign free       = !ov_q || out_o.ready;

  svpp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (acc && in_i.opcode == OP_BYTE),
    .restart_i (acc && in_i.opcode == OP_RESTART),
    .byte_i    (in_i.rx_byte),
    .step_o    (ps)
  );

  svpp_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always_comb begin
    req      = '0;
    req.op   = TOP_READ;
    req.key  = {in_i.object_id, in_i.var_id};
    req.wval = in_i.new_value;
    case (in_i.opcode)
      OP_BYTE: begin
        req.valid = acc && ps.uvalid;
        req.op    = TOP_WRITE;
        req.key   = ps.key;
        req.wval  = ps.uval;
      end
      OP_REGISTER: begin
        req.valid = acc;
        req.op    = TOP_REGISTER;
      end
      OP_READ:  req.valid = acc;
      OP_WRITE: begin
        req.valid = acc;
        req.op    = TOP_WRITE;
      end
      default: req.valid = 1'b0;
    endcase
  end

  always_comb begin
    st_d  = st_q;
    res_d = res_q;
    ov_d  = ov_q && !out_o.ready;
    case (st_q)
      ST_IDLE: begin
        if (acc) begin
          res_d            = '0;
          res_d.peer_node  = ps.node;
          res_d.node_known = (ps.node != NODE_NONE);
          if (in_i.opcode == OP_BYTE) begin
            res_d.update_valid  = ps.uvalid;
            res_d.update_var_id = ps.uvid;
            res_d.update_value  = ps.uval;
            res_d.frame_done    = ps.done;
            res_d.node_captured = ps.capt;
            res_d.error_code    = ps.err;
          end
          st_d = req.valid ? ST_WAIT : ST_FIN;
        end
      end
      ST_WAIT: begin
        if (rsp.done) begin
          if (op_q == OP_READ) begin
            res_d.read_value = rsp.found ? rsp.rdata : VALUE_NONE;
          end
          res_d.update_matched = rsp.found && (op_q == OP_BYTE || op_q == OP_WRITE);
          res_d.table_full     = rsp.full && (op_q == OP_REGISTER);
          st_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (free) begin
          ov_d = 1'b1;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (acc) begin
      op_q <= in_i.opcode;
    end
    if (st_q == ST_FIN && free) begin
      out_q <= res_q;
    end
  end

  assign out_o.valid          = ov_q;
  assign out_o.read_value     = out_q.read_value;
  assign out_o.update_valid   = out_q.update_valid;
  assign out_o.update_var_id  = out_q.update_var_id;
  assign out_o.update_value   = out_q.update_value;
  assign out_o.update_matched = out_q.update_matched;
  assign out_o.frame_done     = out_q.frame_done;
  assign out_o.peer_node      = out_q.peer_node;
  assign out_o.node_known     = out_q.node_known;
  assign out_o.node_captured  = out_q.node_captured;
  assign out_o.error_code     = out_q.error_code;
  assign out_o.table_full     = out_q.table_full;

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FIN && free) |=> (ov_q && st_q == ST_IDLE))
    else $error("finished result not registered");

  a_wait_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (st_q == ST_WAIT))
    else $error("table response outside wait");

  a_req_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid |-> (st_q == ST_IDLE))
    else $error("table request while busy");

endmodule

FILE: sim/svpp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpp_checker
// Watches the word channels of the packet parser, predicts each result from
// the accepted input words and compares it field by field.
// ----------------------------------------------------------------------------
module svpp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  svpp_in_if          in_w,
  svpp_out_if         out_w,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned updates_o,
  output int unsigned errors_o
);
  import svpp_pkg::*;

  typedef enum logic [3:0] {
    PH_HEADER, PH_SKIP, PH_LEAD, PH_COUNT, PH_VIDH, PH_VIDL, PH_TYPE, PH_V1, PH_VH, PH_VL
  } phase_e;

  logic [KEY_W-1:0] keys [TABLE_ENTRIES];
  logic [15:0]      vals [TABLE_ENTRIES];
  int unsigned      n_entries;
  logic [15:0]      node;
  logic [7:0]       hdr [HDR_LEN];
  int unsigned      hpos;
  int unsigned      pay_left;
  phase_e           phase;
  int unsigned      rec_left;
  logic [15:0]      rec_vid;
  logic [7:0]       rec_hi;
  res_t             expected_q [$];

  function automatic int find_key(logic [KEY_W-1:0] k);
    for (int i = 0; i < n_entries; i++)
      if (keys[i] == k) return i;
    return -1;
  endfunction

  task automatic parse_byte(input logic [7:0] b, inout res_t r);
    logic [15:0] len;
    logic [15:0] msg;
    logic        finished;
    int          k;
    finished = 1'b0;
    if (phase == PH_HEADER) begin
      hdr[hpos] = b;
      hpos++;
      if (hpos == HDR_LEN) begin
        len = {hdr[3], hdr[4]};
        msg = {hdr[17], hdr[18]};
        hpos = 0;
        pay_left = (len >= HDR_LEN) ? len - HDR_LEN : 0;
        phase = PH_SKIP;
        if (hdr[1] != 0 || hdr[2] != 0) begin
          r.error_code = ERR_LENGTH;
        end else if (msg == MSG_DISCOVER) begin
          if (node == NODE_NONE) begin
            node = {hdr[5], hdr[6]};
            r.node_captured = 1'b1;
          end
        end else if (msg == MSG_SET || msg == MSG_GET) begin
          if (pay_left == 0) r.error_code = ERR_COUNT;
          else phase = PH_LEAD;
        end
        if (pay_left == 0) begin
          r.frame_done = 1'b1;
          phase = PH_HEADER;
        end
      end
    end else begin
      if (pay_left > 0) pay_left--;
      case (phase)
        PH_LEAD: phase = PH_COUNT;
        PH_COUNT: begin
          rec_left = b;
          if (rec_left == 0) finished = 1'b1;
          else phase = PH_VIDH;
        end
        PH_VIDH: begin
          rec_vid[15:8] = b;
          phase = PH_VIDL;
        end
        PH_VIDL: begin
          rec_vid[7:0] = b;
          phase = PH_TYPE;
        end
        PH_TYPE: begin
          if (b == 8'd1) phase = PH_V1;
          else if (b == 8'd3) phase = PH_VH;
          else begin
            r.error_code = ERR_TYPE;
            phase = PH_SKIP;
          end
        end
        PH_VH: begin
          rec_hi = b;
          phase = PH_VL;
        end
        PH_V1, PH_VL: begin
          r.update_valid  = 1'b1;
          r.update_var_id = rec_vid;
          r.update_value  = (phase == PH_V1) ? {8'd0, b} : {rec_hi, b};
          k = find_key({hdr[10], hdr[9], hdr[8], hdr[7], rec_vid});
          if (k >= 0) begin
            vals[k] = r.update_value;
            r.update_matched = 1'b1;
          end
          if (rec_left > 0) rec_left--;
          if (rec_left == 0) finished = 1'b1;
          else phase = PH_VIDH;
        end
        default: phase = PH_SKIP;
      endcase
      if (finished) begin
        phase = PH_SKIP;
        if (pay_left != 0) r.error_code = ERR_COUNT;
      end
      if (pay_left == 0) begin
        if (phase != PH_SKIP && r.error_code == ERR_NONE) r.error_code = ERR_COUNT;
        r.frame_done = 1'b1;
        phase = PH_HEADER;
        hpos = 0;
      end
    end
  endtask

  task automatic predict_word(input op_e op, input logic [7:0] b, input logic [31:0] obj,
                              input logic [15:0] vid, input logic [15:0] nv);
    res_t r;
    int   k;
    r = '0;
    case (op)
      OP_REGISTER: begin
        if (n_entries < TABLE_ENTRIES) begin
          keys[n_entries] = {obj, vid};
          vals[n_entries] = '0;
          n_entries++;
        end else r.table_full = 1'b1;
      end
      OP_READ: begin
        k = find_key({obj, vid});
        r.read_value = (k >= 0) ? vals[k] : VALUE_NONE;
      end
      OP_WRITE: begin
        k = find_key({obj, vid});
        if (k >= 0) begin
          vals[k] = nv;
          r.update_matched = 1'b1;
        end
      end
      OP_RESTART: begin
        node = NODE_NONE;
        hpos = 0;
        pay_left = 0;
        phase = PH_HEADER;
        rec_left = 0;
      end
      OP_BYTE: parse_byte(b, r);
      default: ;
    endcase
    r.peer_node  = node;
    r.node_known = (node != NODE_NONE);
    expected_q.push_back(r);
  endtask

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] exp);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, exp);
    fail_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      n_entries  = 0;
      node       = NODE_NONE;
      hpos       = 0;
      pay_left   = 0;
      phase      = PH_HEADER;
      rec_left   = 0;
      fail_cnt_o = 0;
      updates_o  = 0;
      errors_o   = 0;
      for (int i = 0; i < HDR_LEN; i++) hdr[i] = '0;
    end else begin
      if (out_w.valid && out_w.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected word", 16'd0, 16'd0);
        end else begin
          e = expected_q.pop_front();
          if (e.update_valid) updates_o++;
          if (e.error_code != ERR_NONE) errors_o++;
          if (out_w.read_value !== e.read_value)
            report("read_value", out_w.read_value, e.read_value);
          if (out_w.update_valid !== e.update_valid)
            report("update_valid", out_w.update_valid, e.update_valid);
          if (out_w.update_var_id !== e.update_var_id)
            report("update_var_id", out_w.update_var_id, e.update_var_id);
          if (out_w.update_value !== e.update_value)
            report("update_value", out_w.update_value, e.update_value);
          if (out_w.update_matched !== e.update_matched)
            report("update_matched", out_w.update_matched, e.update_matched);
          if (out_w.frame_done !== e.frame_done)
            report("frame_done", out_w.frame_done, e.frame_done);
          if (out_w.peer_node !== e.peer_node)
            report("peer_node", out_w.peer_node, e.peer_node);
          if (out_w.node_known !== e.node_known)
            report("node_known", out_w.node_known, e.node_known);
          if (out_w.node_captured !== e.node_captured)
            report("node_captured", out_w.node_captured, e.node_captured);
          if (out_w.error_code !== e.error_code)
            report("error_code", out_w.error_code, e.error_code);
          if (out_w.table_full !== e.table_full)
            report("table_full", out_w.table_full, e.table_full);
        end
      end
      if (in_w.valid && in_w.ready)
        predict_word(op_e'(in_w.opcode), in_w.rx_byte, in_w.object_id, in_w.var_id,
                     in_w.new_value);
    end
    pending_o = expected_q.size();
  end

endmodule

FILE: sim/tb_state_variable_packet_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_state_variable_packet_parser
// Feeds directed and random frames and table requests into the packet parser
// with random stalls on both sides; a checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_state_variable_packet_parser;
  import svpp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned n_updates;
  int unsigned n_errors;
  int unsigned n_words;
  int unsigned cycle_cnt = 0;
  logic        quiet;
  logic        hold_on;
  logic        hold_done;
  logic [31:0] objs [4];
  logic [15:0] vids [4];

  svpp_in_if  in_w ();
  svpp_out_if out_w ();

  state_variable_packet_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  svpp_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_w       (in_w),
    .out_w      (out_w),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .updates_o  (n_updates),
    .errors_o   (n_errors)
  );

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout with %0d words outstanding", pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls, a long hold-off on request
  initial begin
    out_w.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_on) out_w.ready <= 1'b0;
      else out_w.ready <= quiet || ($urandom_range(99) >= 9);
    end
  end

  task automatic send(input op_e op, input logic [7:0] b, input logic [31:0] obj,
                      input logic [15:0] vid, input logic [15:0] nv);
    while (!quiet && $urandom_range(99) < 9) begin
      in_w.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_w.valid     <= 1'b1;
    in_w.opcode    <= op;
    in_w.rx_byte   <= b;
    in_w.object_id <= obj;
    in_w.var_id    <= vid;
    in_w.new_value <= nv;
    @(posedge clk_i);
    while (!in_w.ready) @(posedge clk_i);
    n_words++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send(OP_BYTE, b, $urandom, 16'($urandom), 16'($urandom));
  endtask

  task automatic send_frame(input logic [15:0] msg, input logic [31:0] obj,
                            input logic [15:0] node_id, input logic [7:0] len_hi_x,
                            input int unsigned n_rec, input int unsigned claimed,
                            input int unsigned extra, input int unsigned cut,
                            input logic bad_type);
    logic [7:0]  pay [$];
    logic [7:0]  t;
    logic [15:0] vid;
    logic [15:0] len;
    int unsigned i;
    pay.push_back(8'($urandom));
    pay.push_back(claimed[7:0]);
    for (i = 0; i < n_rec; i++) begin
      vid = ($urandom_range(3) == 0) ? 16'($urandom) : vids[$urandom_range(3)];
      t = (bad_type && $urandom_range(2) == 0) ? 8'($urandom)
          : (($urandom_range(1) != 0) ? 8'd1 : 8'd3);
      pay.push_back(vid[15:8]);
      pay.push_back(vid[7:0]);
      pay.push_back(t);
      pay.push_back(8'($urandom));
      if (t == 8'd3) pay.push_back(8'($urandom));
    end
    for (i = 0; i < extra; i++) pay.push_back(8'($urandom));
    while (cut > 0 && pay.size() > 0) begin
      void'(pay.pop_back());
      cut--;
    end
    len = 16'(HDR_LEN + pay.size());
    for (i = 0; i < HDR_LEN; i++) begin
      case (i)
        1: send_byte(len_hi_x);
        2: send_byte(8'd0);
        3: send_byte(len[15:8]);
        4: send_byte(len[7:0]);
        5: send_byte(node_id[15:8]);
        6: send_byte(node_id[7:0]);
        7: send_byte(obj[7:0]);
        8: send_byte(obj[15:8]);
        9: send_byte(obj[23:16]);
        10: send_byte(obj[31:24]);
        17: send_byte(msg[15:8]);
        18: send_byte(msg[7:0]);
        default: send_byte(8'($urandom));
      endcase
    end
    foreach (pay[j]) send_byte(pay[j]);
  endtask

  task automatic random_frame();
    logic [15:0] msg;
    logic [15:0] node_id;
    logic [7:0]  len_hi;
    int unsigned n;
    int unsigned sel;
    sel = $urandom_range(99);
    msg = (sel < 40) ? MSG_SET : (sel < 75) ? MSG_GET : (sel < 85) ? MSG_DISCOVER
          : 16'($urandom);
    node_id = ($urandom_range(9) == 0) ? NODE_NONE : 16'($urandom);
    len_hi = ($urandom_range(29) == 0) ? 8'(1 + $urandom_range(254)) : 8'd0;
    n = $urandom_range(4);
    sel = $urandom_range(99);
    send_frame(msg, objs[$urandom_range(3)], node_id, len_hi,
               n, (sel < 85) ? n : $urandom_range(5), (sel >= 90) ? $urandom_range(1, 3) : 0,
               (sel >= 85 && sel < 90) ? $urandom_range(1, 3) : 0, sel >= 95);
  endtask

  task automatic table_op();
    int unsigned sel;
    int unsigned o;
    sel = $urandom_range(99);
    o = $urandom_range(3);
    if (sel < 10)
      send(OP_REGISTER, 8'($urandom), objs[o], vids[$urandom_range(3)], 16'($urandom));
    else if (sel < 50)
      send(OP_READ, 8'($urandom), objs[o], vids[$urandom_range(3)], 16'($urandom));
    else if (sel < 85)
      send(OP_WRITE, 8'($urandom), objs[o], vids[$urandom_range(3)], 16'($urandom));
    else if (sel < 92)
      send(OP_RESTART, 8'($urandom), $urandom, 16'($urandom), 16'($urandom));
    else if (sel < 96)
      send(op_e'(3'd5 + 3'($urandom_range(2))), 8'($urandom), $urandom, 16'($urandom),
           16'($urandom));
    else send(OP_READ, 8'($urandom), $urandom, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    rst_ni = 1'b0;
    n_words = 0;
    quiet = 1'b0;
    hold_on = 1'b0;
    hold_done = 1'b0;
    in_w.valid = 1'b0;
    in_w.opcode = OP_BYTE;
    in_w.rx_byte = '0;
    in_w.object_id = '0;
    in_w.var_id = '0;
    in_w.new_value = '0;
    objs[0] = 32'h0000_0000;
    objs[1] = 32'hFFFF_FFFF;
    objs[2] = $urandom;
    objs[3] = $urandom;
    vids[0] = 16'h0000;
    vids[1] = 16'hFFFF;
    vids[2] = 16'($urandom);
    vids[3] = 16'($urandom);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: table ops on empty table, registrations, frames of each kind
    send(OP_READ, 8'h00, objs[1], vids[1], 16'h0);
    send(OP_WRITE, 8'hFF, objs[0], vids[0], 16'hFFFF);
    for (int i = 0; i < 4; i++) send(OP_REGISTER, 8'h00, objs[i], vids[i], 16'h0);
    send(OP_REGISTER, 8'h00, objs[0], vids[0], 16'h0);
    send(OP_WRITE, 8'h00, objs[0], vids[0], 16'hFFFF);
    send(OP_READ, 8'h00, objs[0], vids[0], 16'h0);
    send_frame(MSG_DISCOVER, objs[0], NODE_NONE, 8'd0, 0, 0, 0, 0, 1'b0);
    send_frame(MSG_DISCOVER, objs[0], 16'h1234, 8'd0, 0, 0, 2, 0, 1'b0);
    send_frame(MSG_DISCOVER, objs[0], 16'h5678, 8'd0, 0, 0, 0, 0, 1'b0);
    send_frame(MSG_SET, objs[1], 16'h0, 8'd0, 3, 3, 0, 0, 1'b0);
    send_frame(MSG_GET, objs[2], 16'h0, 8'd0, 2, 2, 0, 0, 1'b0);
    send_frame(MSG_SET, objs[1], 16'h0, 8'd0, 0, 0, 0, 0, 1'b0);
    send_frame(MSG_SET, objs[1], 16'h0, 8'd0, 0, 0, 0, 2, 1'b0);
    send_frame(MSG_SET, objs[3], 16'h0, 8'd0, 2, 3, 0, 0, 1'b0);
    send_frame(MSG_SET, objs[3], 16'h0, 8'd0, 2, 1, 0, 0, 1'b0);
    send_frame(MSG_GET, objs[3], 16'h0, 8'd0, 3, 3, 0, 0, 1'b1);
    send_frame(MSG_SET, objs[0], 16'h0, 8'hFF, 1, 1, 0, 0, 1'b0);
    send(OP_RESTART, 8'h00, 32'h0, 16'h0, 16'h0);
    send(op_e'(3'd7), 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 12; i++) send(OP_REGISTER, 8'h00, objs[i % 4], vids[i % 4], 16'h0);
    send(OP_READ, 8'h00, objs[3], vids[3], 16'h0);

    // random: mostly well formed frames, table ops and partial frames
    while (n_words < 750) begin
      quiet = (n_words >= 300 && n_words < 400);
      if (n_words >= 500 && !hold_done) begin
        hold_done = 1'b1;
        fork
          begin
            hold_on = 1'b1;
            repeat (400) @(posedge clk_i);
            hold_on = 1'b0;
          end
        join_none
      end
      if ($urandom_range(9) < 6) random_frame();
      else if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 10)) send_byte(8'($urandom));
        send(OP_RESTART, 8'h00, $urandom, 16'($urandom), 16'($urandom));
      end else table_op();
    end
    in_w.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("%0d words sent, %0d records parsed, %0d frame errors seen",
             n_words, n_updates, n_errors);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
